@@ rtl/core/lpp_pkg.sv @@
// Shared types and constants of the moving-pad landing point predictor.
package lpp_pkg;

	// Configuration register indexes.
	typedef enum logic [2:0] {
		REG_BAND_ONE   = 3'd0,
		REG_BAND_TWO   = 3'd1,
		REG_BAND_THREE = 3'd2,
		REG_FALLBACK   = 3'd3,
		REG_OVERHEAD   = 3'd4,
		REG_HOVER      = 3'd5
	} reg_index_t;

	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 32;
	localparam int unsigned TIME_W     = 16;
	localparam int unsigned HOVER_W    = 32;
	localparam int unsigned DIST_W     = 32;
	localparam int unsigned SQ_W       = 64;

	// Register values after reset.
	localparam logic [TIME_W-1:0]  BAND_ONE_RST   = 16'd1920;
	localparam logic [TIME_W-1:0]  BAND_TWO_RST   = 16'd2176;
	localparam logic [TIME_W-1:0]  BAND_THREE_RST = 16'd2560;
	localparam logic [TIME_W-1:0]  FALLBACK_RST   = 16'd2176;
	localparam logic [TIME_W-1:0]  OVERHEAD_RST   = 16'd192;
	localparam logic [HOVER_W-1:0] HOVER_RST      = 32'd19661;

	// Band edges as tenths of a metre per second: 0.1, 1.1, 2.1 and 3.1.
	localparam int unsigned EDGE_ONE   = 1;
	localparam int unsigned EDGE_TWO   = 11;
	localparam int unsigned EDGE_THREE = 21;
	localparam int unsigned EDGE_FOUR  = 31;

endpackage

@@ rtl/core/lpp_isqrt.sv @@
// Pipelined integer square root, one result bit per stage, with a tag carried alongside.
module lpp_isqrt import lpp_pkg::*; #(
	parameter int unsigned TAG_W = 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_valid,
	input  logic [SQ_W-1:0]   radicand,
	input  logic [TAG_W-1:0]  in_tag,
	output logic              out_valid,
	output logic [DIST_W-1:0] root,
	output logic [TAG_W-1:0]  out_tag
);

	logic              vld_s  [DIST_W+1];
	logic [SQ_W-1:0]   rem_s  [DIST_W+1];
	logic [DIST_W-1:0] root_s [DIST_W+1];
	logic [TAG_W-1:0]  tag_s  [DIST_W+1];

	assign vld_s[0]  = in_valid;
	assign rem_s[0]  = radicand;
	assign root_s[0] = '0;
	assign tag_s[0]  = in_tag;

	// Each stage decides one root bit, from the top down, keeping the remainder n - r*r.
	for (genvar g = 0; g < DIST_W; g++) begin : g_step
		localparam int unsigned B = DIST_W - 1 - g;
		logic [SQ_W+1:0] cand;
		logic            take;

		assign cand = ({{(SQ_W+2-DIST_W){1'b0}}, root_s[g]} << (B + 1))
			+ ((SQ_W+2)'(1) << (2 * B));
		assign take = {2'b00, rem_s[g]} >= cand;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[g+1] <= 1'b0;
			end else if (en) begin
				vld_s[g+1] <= vld_s[g];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[g+1]  <= take ? rem_s[g] - cand[SQ_W-1:0] : rem_s[g];
				root_s[g+1] <= take ? (root_s[g] | (DIST_W'(1) << B)) : root_s[g];
				tag_s[g+1]  <= tag_s[g];
			end
		end
	end

	assign out_valid = vld_s[DIST_W];
	assign root      = root_s[DIST_W];
	assign out_tag   = tag_s[DIST_W];

endmodule

@@ rtl/core/moving_pad_landing_point_predictor_top.sv @@
// Top level of the moving-pad landing point predictor pipeline.
// Every accepted item passes through 40 register stages on its way to the output register
// (seven datapath, 32 root, one output).
// Throughput: one item per cycle; the whole pipeline advances together and stops
// only while the output register holds an item that is not taken.
// Reset (arst_n low) clears all valid bits and loads the configuration registers with their defaults.
module moving_pad_landing_point_predictor_top import lpp_pkg::*; #(
	parameter int unsigned FRAC_BITS   = 16,
	parameter int unsigned COORD_WIDTH = 32,
	localparam int unsigned IN_W  = ((9 * COORD_WIDTH + 7) / 8) * 8,
	localparam int unsigned OUT_W = ((3 * COORD_WIDTH + 2 * DIST_W + 7) / 8) * 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	// pad_x, pad_y, pad_z, pad_vx, pad_vy, pad_vz, drone_x, drone_y, drone_z
	input  logic [IN_W-1:0]       s_axis_tdata,
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	// target_x, target_y, target_z, separation, landing_delay
	output logic [OUT_W-1:0]      m_axis_tdata
);

	localparam int unsigned CW  = COORD_WIDTH;
	localparam int unsigned SW  = (CW + 5 > FRAC_BITS + 6) ? CW + 5 : FRAC_BITS + 6;
	localparam int unsigned PW  = CW + TIME_W;
	localparam int unsigned MW  = (CW + 1 > DIST_W) ? CW + 1 : DIST_W + 1;
	localparam int unsigned TAG = 2 * CW + 1;

	localparam logic [SW-1:0] LIM1 = SW'(EDGE_ONE)   << FRAC_BITS;
	localparam logic [SW-1:0] LIM2 = SW'(EDGE_TWO)   << FRAC_BITS;
	localparam logic [SW-1:0] LIM3 = SW'(EDGE_THREE) << FRAC_BITS;
	localparam logic [SW-1:0] LIM4 = SW'(EDGE_FOUR)  << FRAC_BITS;

	// Configuration registers.
	logic [TIME_W-1:0]  band_one_q, band_two_q, band_three_q, fallback_q, overhead_q;
	logic [HOVER_W-1:0] hover_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			band_one_q   <= BAND_ONE_RST;
			band_two_q   <= BAND_TWO_RST;
			band_three_q <= BAND_THREE_RST;
			fallback_q   <= FALLBACK_RST;
			overhead_q   <= OVERHEAD_RST;
			hover_q      <= HOVER_RST;
		end else if (cfg_we) begin
			case (reg_index_t'(cfg_index))
				REG_BAND_ONE:   band_one_q   <= cfg_wdata[TIME_W-1:0];
				REG_BAND_TWO:   band_two_q   <= cfg_wdata[TIME_W-1:0];
				REG_BAND_THREE: band_three_q <= cfg_wdata[TIME_W-1:0];
				REG_FALLBACK:   fallback_q   <= cfg_wdata[TIME_W-1:0];
				REG_OVERHEAD:   overhead_q   <= cfg_wdata[TIME_W-1:0];
				REG_HOVER:      hover_q      <= cfg_wdata[HOVER_W-1:0];
				default:        ;
			endcase
		end
	end

	// Global advance: everything moves unless the output item is stalled.
	logic en;
	logic out_valid_q;
	assign en            = !out_valid_q || m_axis_tready;
	assign s_axis_tready = en;

	// Input field unpacking.
	logic signed [CW-1:0] in_f [9];
	for (genvar i = 0; i < 9; i++) begin : g_unpack
		assign in_f[i] = s_axis_tdata[i*CW +: CW];
	end

	function automatic logic [CW-1:0] mag_of(input logic [CW-1:0] v);
		return v[CW-1] ? CW'(-v) : v;
	endfunction

	// Stage 1: velocity magnitudes and speed sum.
	logic                 v_s1;
	logic [CW-1:0]        pos_s1 [3];
	logic [CW-1:0]        drn_s1 [3];
	logic [CW-1:0]        mv_s1  [3];
	logic                 neg_s1 [3];
	logic [CW:0]          spd_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (en) v_s1 <= s_axis_tvalid;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				pos_s1[i] <= in_f[i];
				drn_s1[i] <= in_f[i+6];
				mv_s1[i]  <= mag_of(in_f[i+3]);
				neg_s1[i] <= in_f[i+3][CW-1];
			end
			spd_s1 <= {1'b0, mag_of(in_f[3])} + {1'b0, mag_of(in_f[4])};
		end
	end

	// Stage 2: speed band lookup selects the lead time.
	logic              v_s2;
	logic [CW-1:0]     pos_s2 [3];
	logic [CW-1:0]     drn_s2 [3];
	logic [CW-1:0]     mv_s2  [3];
	logic              neg_s2 [3];
	logic [TIME_W-1:0] t_s2;
	logic [SW-1:0]     s10;
	logic [TIME_W-1:0] t_sel;

	assign s10 = (SW'(spd_s1) << 3) + (SW'(spd_s1) << 1);

	always_comb begin
		if (s10 > LIM1 && s10 < LIM2)      t_sel = band_one_q;
		else if (s10 > LIM2 && s10 < LIM3) t_sel = band_two_q;
		else if (s10 > LIM3 && s10 < LIM4) t_sel = band_three_q;
		else                               t_sel = fallback_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else if (en) v_s2 <= v_s1;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pos_s2 <= pos_s1;
			drn_s2 <= drn_s1;
			mv_s2  <= mv_s1;
			neg_s2 <= neg_s1;
			t_s2   <= t_sel;
		end
	end

	// Stage 3: velocity magnitude times lead time.
	logic          v_s3;
	logic [CW-1:0] pos_s3 [3];
	logic [CW-1:0] drn_s3 [3];
	logic [PW-1:0] prod_s3 [3];
	logic          neg_s3 [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s3 <= 1'b0;
		else if (en) v_s3 <= v_s2;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				prod_s3[i] <= PW'(mv_s2[i]) * PW'(t_s2);
			end
			pos_s3 <= pos_s2;
			drn_s3 <= drn_s2;
			neg_s3 <= neg_s2;
		end
	end

	// Stage 4: round the offset, add it to the position and saturate.
	logic          v_s4;
	logic [CW-1:0] tgt_s4 [3];
	logic [CW-1:0] drn_s4 [3];
	logic [CW-1:0] pred [3];

	for (genvar i = 0; i < 3; i++) begin : g_pred
		logic [PW:0]         rnd;
		logic signed [CW+9:0] off;
		logic signed [CW+9:0] sum;
		assign rnd = {1'b0, prod_s3[i]} + (PW+1)'(128);
		assign off = neg_s3[i] ? -$signed({1'b0, rnd[PW:8]}) : $signed({1'b0, rnd[PW:8]});
		assign sum = $signed({{10{pos_s3[i][CW-1]}}, pos_s3[i]}) + off;
		always_comb begin
			if (sum[CW+9:CW-1] == '0 || sum[CW+9:CW-1] == '1) begin
				pred[i] = sum[CW-1:0];
			end else if (sum[CW+9]) begin
				pred[i] = {1'b1, {(CW-1){1'b0}}};
			end else begin
				pred[i] = {1'b0, {(CW-1){1'b1}}};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s4 <= 1'b0;
		else if (en) v_s4 <= v_s3;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tgt_s4 <= pred;
			drn_s4 <= drn_s3;
		end
	end

	// Stage 5: differences to the drone and their magnitudes.
	logic              v_s5;
	logic [CW-1:0]     tx_s5, ty_s5;
	logic [DIST_W-1:0] a_s5 [3];
	logic              big_s5;
	logic [MW-1:0]     dmag [3];
	logic [2:0]        dbig;

	for (genvar i = 0; i < 3; i++) begin : g_diff
		logic [CW:0] d;
		assign d       = {tgt_s4[i][CW-1], tgt_s4[i]} - {drn_s4[i][CW-1], drn_s4[i]};
		assign dmag[i] = MW'(d[CW] ? (CW+1)'(-d) : d);
		assign dbig[i] = |dmag[i][MW-1:DIST_W];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s5 <= 1'b0;
		else if (en) v_s5 <= v_s4;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tx_s5  <= tgt_s4[0];
			ty_s5  <= tgt_s4[1];
			big_s5 <= |dbig;
			for (int i = 0; i < 3; i++) a_s5[i] <= dmag[i][DIST_W-1:0];
		end
	end

	// Stage 6: squares.
	logic            v_s6;
	logic [CW-1:0]   tx_s6, ty_s6;
	logic [SQ_W-1:0] sq_s6 [3];
	logic            big_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s6 <= 1'b0;
		else if (en) v_s6 <= v_s5;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) sq_s6[i] <= SQ_W'(a_s5[i]) * SQ_W'(a_s5[i]);
			tx_s6  <= tx_s5;
			ty_s6  <= ty_s5;
			big_s6 <= big_s5;
		end
	end

	// Stage 7: sum of squares with overflow detection.
	logic            v_s7;
	logic [SQ_W-1:0] sum_s7;
	logic [TAG-1:0]  tag_s7;
	logic [SQ_W+1:0] sq_sum;

	assign sq_sum = (SQ_W+2)'(sq_s6[0]) + (SQ_W+2)'(sq_s6[1]) + (SQ_W+2)'(sq_s6[2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s7 <= 1'b0;
		else if (en) v_s7 <= v_s6;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sum_s7 <= sq_sum[SQ_W-1:0];
			tag_s7 <= {tx_s6, ty_s6, big_s6 || (|sq_sum[SQ_W+1:SQ_W])};
		end
	end

	// Square root.
	logic              sq_valid;
	logic [DIST_W-1:0] sq_root;
	logic [TAG-1:0]    sq_tag;

	lpp_isqrt #(
		.TAG_W(TAG)
	) u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (v_s7),
		.radicand (sum_s7),
		.in_tag   (tag_s7),
		.out_valid(sq_valid),
		.root     (sq_root),
		.out_tag  (sq_tag)
	);

	// Output stage: saturated separation and landing delay.
	logic [DIST_W-1:0] sep;
	logic [DIST_W+1:0] dly;
	logic [DIST_W-1:0] sep_q, dly_q;
	logic [CW-1:0]     tx_q, ty_q;

	assign sep = sq_tag[0] ? '1 : sq_root;
	assign dly = (DIST_W+2)'(sep >> 1) + ((DIST_W+2)'(overhead_q) << (FRAC_BITS - 8));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if (en) out_valid_q <= sq_valid;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tx_q  <= sq_tag[TAG-1:CW+1];
			ty_q  <= sq_tag[CW:1];
			sep_q <= sep;
			dly_q <= (|dly[DIST_W+1:DIST_W]) ? '1 : dly[DIST_W-1:0];
		end
	end

	logic [CW-1:0] tz;
	assign tz = CW'($signed(hover_q));

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = OUT_W'({dly_q, sep_q, tz, ty_q, tx_q});

	// Checks.
	a_accept_enters: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> v_s1)
		else $error("accepted item did not enter the first stage");
	a_delay_floor: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> dly_q >= (sep_q >> 1))
		else $error("landing delay below half the separation");
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(sep_q) && $stable(tx_q) && out_valid_q)
		else $error("output changed while stalled");
	a_sat_flag: assert property (@(posedge clk) disable iff (!arst_n)
		sq_valid && sq_tag[0] |-> sep == '1)
		else $error("overflowed distance not saturated");

endmodule
